// ===== rtl/motor_current_pi_controller_unit_assert.svh =====
// Assertion macros for the checker module of the current controller.
`ifndef MOTOR_CURRENT_PI_CONTROLLER_UNIT_ASSERT_SVH
`define MOTOR_CURRENT_PI_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MCPI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("current controller check failed");

// Next-cycle implication, disabled while reset is low.
`define MCPI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("current controller check failed");

`endif

// ===== rtl/mcpi_pkg.sv =====
// Types, constants and control program of the motor current PI controller.
package mcpi_pkg;

  localparam int unsigned PWM_TOP     = 1999;
  localparam int unsigned TEST_LENGTH = 100;
  localparam int unsigned PHASE_Q1    = TEST_LENGTH / 4;
  localparam int unsigned PHASE_HALF  = TEST_LENGTH / 2;
  localparam int unsigned PHASE_Q3    = (3 * TEST_LENGTH) / 4;

  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned DRIVE_FULL  = 100 * 65536;
  // floor(q / 100) = (q * RECIP) >> RECIP_SHIFT, exact for q below 2^18
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + 99) / 100;

  localparam int unsigned CMP_W   = 11;
  localparam int unsigned MUL_W   = 25;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned DRV_W   = 42;
  localparam int unsigned MAG_W   = 23;
  localparam int unsigned QUO_W   = 18;
  localparam int unsigned INTEG_W = 18;
  localparam int unsigned ERR_W   = 17;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PWM   = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_TRACK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_TARGET = 3'd2,
    REG_LIMIT  = 3'd3,
    REG_AMP    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SAVE_DRV,
    ACT_SUM_DRV,
    ACT_SCALE,
    ACT_FINISH
  } act_e;

  typedef enum logic [1:0] {MA_ERR, MA_ACC, MA_MAG, MA_QUO} mul_a_e;
  typedef enum logic [1:0] {MB_KP, MB_KI, MB_TOP, MB_RECIP} mul_b_e;
  typedef enum logic [1:0] {JMP_NONE, JMP_IDLE, JMP_PWM} jmp_e;

  typedef logic [2:0] step_t;

  typedef struct packed {
    act_e   act;
    logic   mul_en;
    mul_a_e mul_a;
    mul_b_e mul_b;
    jmp_e   jmp;
    step_t  target;
    logic   last;
  } ctl_t;

  // Control program: one word per step.
  function automatic ctl_t ucode(step_t pc);
    ctl_t w;
    w = '{act: ACT_NONE, mul_en: 1'b0, mul_a: MA_ERR, mul_b: MB_KP,
          jmp: JMP_NONE, target: 3'd0, last: 1'b0};
    case (pc)
      3'd0: begin
        w.act = ACT_LOAD;  w.jmp = JMP_IDLE; w.target = 3'd7;
      end
      3'd1: begin
        w.mul_en = 1'b1; w.mul_a = MA_ERR; w.mul_b = MB_KP;
        w.jmp = JMP_PWM; w.target = 3'd4;
      end
      3'd2: begin
        w.act = ACT_SAVE_DRV; w.mul_en = 1'b1; w.mul_a = MA_ACC; w.mul_b = MB_KI;
      end
      3'd3: begin
        w.act = ACT_SUM_DRV;
      end
      3'd4: begin
        w.mul_en = 1'b1; w.mul_a = MA_MAG; w.mul_b = MB_TOP;
      end
      3'd5: begin
        w.act = ACT_SCALE;
      end
      3'd6: begin
        w.mul_en = 1'b1; w.mul_a = MA_QUO; w.mul_b = MB_RECIP;
      end
      3'd7: begin
        w.act = ACT_FINISH; w.last = 1'b1;
      end
      default: begin
        w.act = ACT_NONE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/motor_current_pi_controller_unit.sv =====
// Motor current PI controller: microcoded sequencer around one shared multiplier.
// Steps: load, P product, I product, drive sum, period product, scale, reciprocal, finish;
// manual PWM skips I product and drive sum, idle skips to finish; one shared 25x25 multiplier.
// A new tick is taken while the previous result waits in the output register.
// Reset (rst_ni low, asynchronous): integrator, test counter and phase cleared, gains
// and limits back to their defaults, no result pending.
module motor_current_pi_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] measured_current, [23:16] manual_duty_percent
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [10:0] compare_value, [11] direction,
                                      // [27:12] reference_current, [31:28] zero
  output logic        m_axis_tlast    // test_finished
);

  localparam int unsigned PW = mcpi_pkg::PROD_W;
  localparam int unsigned DW = mcpi_pkg::DRV_W;

  // ---------------------------------------------------------------------------
  // Config registers, always ready: write only while the sequencer is idle; not enforced.
  // ---------------------------------------------------------------------------
  logic signed [23:0] kp_q, ki_q;
  logic signed [15:0] target_q;
  logic        [15:0] limit_q;
  logic        [14:0] amp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= -24'sd13631;
      ki_q     <= -24'sd655;
      target_q <= 16'sd0;
      limit_q  <= 16'd1000;
      amp_q    <= 15'd200;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mcpi_pkg::cfg_reg_e'(cfg_index_i))
        mcpi_pkg::REG_KP:     kp_q     <= cfg_data_i;
        mcpi_pkg::REG_KI:     ki_q     <= cfg_data_i;
        mcpi_pkg::REG_TARGET: target_q <= cfg_data_i[15:0];
        mcpi_pkg::REG_LIMIT:  limit_q  <= cfg_data_i[15:0];
        mcpi_pkg::REG_AMP:    amp_q    <= cfg_data_i[14:0];
        default: ; // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer control
  // ---------------------------------------------------------------------------
  logic              busy_q;
  mcpi_pkg::step_t   pc_q, pc_d;
  mcpi_pkg::ctl_t    ctl;
  logic              in_xfer, out_free, step_go, jump_taken;
  logic              m_tvalid_q;

  mcpi_pkg::mode_e   op_q;
  logic signed [15:0] meas_q;
  logic signed [7:0]  duty_q;

  assign ctl           = mcpi_pkg::ucode(pc_q);
  assign s_axis_tready = !busy_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  // The final step writes the output register, so it waits for that register to drain.
  assign out_free      = !m_tvalid_q || m_axis_tready;
  assign step_go       = busy_q && (!ctl.last || out_free);

  always_comb begin
    case (ctl.jmp)
      mcpi_pkg::JMP_IDLE: jump_taken = (op_q == mcpi_pkg::MODE_IDLE);
      mcpi_pkg::JMP_PWM:  jump_taken = (op_q == mcpi_pkg::MODE_PWM);
      default:            jump_taken = 1'b0;
    endcase
  end

  always_comb begin
    if (ctl.last)        pc_d = '0;
    else if (jump_taken) pc_d = ctl.target;
    else                 pc_d = pc_q + 3'd1;
  end

  // ---------------------------------------------------------------------------
  // Load step: reference, error, clamped integrator, test wave bookkeeping
  // ---------------------------------------------------------------------------
  logic signed [mcpi_pkg::INTEG_W-1:0] integ_q;
  logic        [6:0]                   count_q;
  logic                                phase_q;

  logic                                phase_nx, test_end;
  logic        [7:0]                   count_inc;
  logic signed [15:0]                  ref_c;
  logic signed [mcpi_pkg::ERR_W-1:0]   err_c;
  logic signed [18:0]                  sum_c, lim_c;
  logic signed [mcpi_pkg::INTEG_W-1:0] acc_c;
  logic signed [7:0]                   duty_sat;
  logic        [6:0]                   duty_mag;

  always_comb begin
    phase_nx = phase_q;
    if (count_q == 7'(mcpi_pkg::PHASE_Q1))   phase_nx = 1'b1;
    if (count_q == 7'(mcpi_pkg::PHASE_HALF)) phase_nx = 1'b0;
    if (count_q == 7'(mcpi_pkg::PHASE_Q3))   phase_nx = 1'b1;
  end

  assign count_inc = {1'b0, count_q} + 8'd1;
  assign test_end  = (count_inc >= 8'(mcpi_pkg::TEST_LENGTH));

  always_comb begin
    case (op_q)
      mcpi_pkg::MODE_TEST:  ref_c = phase_nx ? -$signed({1'b0, amp_q}) : $signed({1'b0, amp_q});
      mcpi_pkg::MODE_TRACK: ref_c = target_q;
      default:              ref_c = 16'sd0;
    endcase
  end

  assign err_c = {ref_c[15], ref_c} - {meas_q[15], meas_q};
  assign sum_c = {integ_q[mcpi_pkg::INTEG_W-1], integ_q} + {{2{err_c[mcpi_pkg::ERR_W-1]}}, err_c};
  assign lim_c = $signed({3'b000, limit_q});

  // Anti-windup: hold the integrator within plus or minus the limit.
  always_comb begin
    if (sum_c > lim_c)       acc_c = lim_c[mcpi_pkg::INTEG_W-1:0];
    else if (sum_c < -lim_c) acc_c = 18'(-lim_c);
    else                     acc_c = sum_c[mcpi_pkg::INTEG_W-1:0];
  end

  always_comb begin
    if (duty_q > 8'sd100)       duty_sat = 8'sd100;
    else if (duty_q < -8'sd100) duty_sat = -8'sd100;
    else                        duty_sat = duty_q;
  end
  assign duty_mag = duty_sat[7] ? 7'(-duty_sat) : duty_sat[6:0];

  // ---------------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------------
  logic signed [mcpi_pkg::ERR_W-1:0]   err_q;
  logic signed [mcpi_pkg::INTEG_W-1:0] acc_q;
  logic        [mcpi_pkg::MAG_W-1:0]   mag_q;
  logic        [mcpi_pkg::QUO_W-1:0]   quo_q;
  logic signed [mcpi_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]                prod_q;

  always_comb begin
    case (ctl.mul_a)
      mcpi_pkg::MA_ERR: mul_a = {{8{err_q[mcpi_pkg::ERR_W-1]}}, err_q};
      mcpi_pkg::MA_ACC: mul_a = {{7{acc_q[mcpi_pkg::INTEG_W-1]}}, acc_q};
      mcpi_pkg::MA_MAG: mul_a = {2'b00, mag_q};
      mcpi_pkg::MA_QUO: mul_a = {7'd0, quo_q};
      default:          mul_a = '0;
    endcase
    case (ctl.mul_b)
      mcpi_pkg::MB_KP:    mul_b = {kp_q[23], kp_q};
      mcpi_pkg::MB_KI:    mul_b = {ki_q[23], ki_q};
      mcpi_pkg::MB_TOP:   mul_b = 25'(mcpi_pkg::PWM_TOP);
      mcpi_pkg::MB_RECIP: mul_b = 25'(mcpi_pkg::RECIP);
      default:            mul_b = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Drive sum and clamp to plus or minus full scale
  // ---------------------------------------------------------------------------
  localparam logic signed [DW:0] DRV_MAX = (DW + 1)'(mcpi_pkg::DRIVE_FULL);

  logic signed [DW-1:0] drive_q;
  logic signed [DW:0]   drv_sum, drv_clamp, drv_neg;

  assign drv_sum = {drive_q[DW-1], drive_q} + {prod_q[DW-1], prod_q[DW-1:0]};

  always_comb begin
    if (drv_sum > DRV_MAX)       drv_clamp = DRV_MAX;
    else if (drv_sum < -DRV_MAX) drv_clamp = -DRV_MAX;
    else                         drv_clamp = drv_sum;
  end
  assign drv_neg = -drv_clamp;

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic                 dir_q, fin_q;
  logic signed [15:0]   ref_q;
  logic [mcpi_pkg::CMP_W-1:0] out_cmp_q;
  logic                 out_dir_q, out_fin_q;
  logic [15:0]          out_ref_q;

  // Control state and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pc_q       <= '0;
      m_tvalid_q <= 1'b0;
      integ_q    <= '0;
      count_q    <= '0;
      phase_q    <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
      end else if (step_go) begin
        pc_q <= pc_d;
        if (ctl.last) busy_q <= 1'b0;
        if (ctl.act == mcpi_pkg::ACT_LOAD) begin
          if (op_q == mcpi_pkg::MODE_TEST) begin
            // Finishing a test run clears its counter, phase and integrator.
            integ_q <= test_end ? '0 : acc_c;
            count_q <= test_end ? '0 : count_inc[6:0];
            phase_q <= test_end ? 1'b0 : phase_nx;
          end else if (op_q == mcpi_pkg::MODE_TRACK) begin
            integ_q <= acc_c;
          end
        end
      end
      // Raise valid on the final step; otherwise drop it once the result is taken.
      if (step_go && ctl.last)  m_tvalid_q <= 1'b1;
      else if (m_axis_tready)   m_tvalid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= mcpi_pkg::mode_e'(s_axis_tuser);
      meas_q <= s_axis_tdata[15:0];
      duty_q <= s_axis_tdata[23:16];
    end
    if (step_go) begin
      if (ctl.mul_en) prod_q <= mul_a * mul_b;
      case (ctl.act)
        mcpi_pkg::ACT_LOAD: begin
          ref_q <= ref_c;
          err_q <= err_c;
          acc_q <= acc_c;
          fin_q <= (op_q == mcpi_pkg::MODE_TEST) && test_end;
          if (op_q == mcpi_pkg::MODE_PWM) begin
            dir_q <= !duty_sat[7] && (duty_sat != 8'sd0);
            mag_q <= {16'd0, duty_mag};
          end else begin
            dir_q <= 1'b0;
            mag_q <= '0;
          end
        end
        mcpi_pkg::ACT_SAVE_DRV: drive_q <= prod_q[DW-1:0];
        mcpi_pkg::ACT_SUM_DRV: begin
          dir_q <= (drv_clamp > 0);
          mag_q <= drv_clamp[DW] ? drv_neg[mcpi_pkg::MAG_W-1:0]
                                 : drv_clamp[mcpi_pkg::MAG_W-1:0];
        end
        mcpi_pkg::ACT_SCALE: begin
          // Manual duty is a whole percent; PI drive carries 16 fraction bits.
          quo_q <= (op_q == mcpi_pkg::MODE_PWM)
                   ? prod_q[mcpi_pkg::QUO_W-1:0]
                   : prod_q[mcpi_pkg::FRAC_W +: mcpi_pkg::QUO_W];
        end
        mcpi_pkg::ACT_FINISH: begin
          out_cmp_q <= (op_q == mcpi_pkg::MODE_IDLE) ? '0
                       : prod_q[mcpi_pkg::RECIP_SHIFT +: mcpi_pkg::CMP_W];
          out_dir_q <= dir_q;
          out_fin_q <= fin_q;
          out_ref_q <= ref_q;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {4'd0, out_ref_q, out_dir_q, out_cmp_q};
  assign m_axis_tlast  = out_fin_q;

endmodule

// ===== rtl/mcpi_checker.sv =====
// Port-level checks on the motor current PI controller, bound to the top level.
`include "motor_current_pi_controller_unit_assert.svh"

module mcpi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result holds.
  `MCPI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Compare value never passes the PWM period.
  `MCPI_ASSERT_IMP(a_cmp_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[10:0] <= 11'(mcpi_pkg::PWM_TOP))

  // The sequencer works on one tick at a time.
  `MCPI_ASSERT_NXT(a_one_tick, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind motor_current_pi_controller_unit mcpi_checker u_mcpi_checker (.*);

// ===== tb/sv/motor_current_pi_controller_unit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the current controller: watches all channels, predicts each tick and compares.
module motor_current_pi_controller_unit_checker
  import mcpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // [15:0] measured_current, [23:16] manual_duty_percent
  input  logic [1:0]  s_tuser_i,   // [1:0] operation
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [10:0] compare_value, [11] direction,
                                   // [27:12] reference_current, [31:28] zero
  input  logic        m_tlast_i,   // test_finished
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic [CMP_W-1:0]   compare;
    logic               direction;
    logic               finished;
    logic signed [15:0] reference_ma;
  } pwm_result_t;

  // Shadow copy of the controller settings and loop state
  logic signed [23:0]        kp_q16;
  logic signed [23:0]        ki_q16;
  logic signed [15:0]        target_ma;
  logic [15:0]               integ_limit;
  logic [14:0]               amplitude_ma;
  logic signed [INTEG_W-1:0] error_sum;
  logic [6:0]                wave_tick;
  logic                      wave_low;

  pwm_result_t pending_results[$];
  int unsigned fault_count;

  function automatic void run_pi(input longint setpoint, input longint current,
                                 output logic [CMP_W-1:0] cmp, output logic dir);
    longint err, acc, drive, mag, full, quot;
    full = longint'(DRIVE_FULL);
    err = setpoint - current;
    // anti-windup: clamp the integrator before it feeds the drive
    acc = longint'(error_sum) + err;
    if (acc > longint'(integ_limit)) acc = longint'(integ_limit);
    if (acc < -longint'(integ_limit)) acc = -longint'(integ_limit);
    error_sum = acc[INTEG_W-1:0];
    drive = longint'(kp_q16) * err + longint'(ki_q16) * acc;
    if (drive > full) drive = full;
    if (drive < -full) drive = -full;
    dir = (drive > 0);
    mag = dir ? drive : -drive;
    quot = longint'(PWM_TOP) * mag / full;
    cmp = quot[CMP_W-1:0];
  endfunction

  function automatic pwm_result_t predict_tick(input mode_e op,
                                               input logic signed [15:0] meas,
                                               input logic signed [7:0] duty);
    pwm_result_t r;
    longint      pct, setpoint;
    logic [7:0]  next_tick;
    r = '0;
    case (op)
      MODE_PWM: begin
        pct = longint'(duty);
        if (pct > 100) pct = 100;
        if (pct < -100) pct = -100;
        if (pct > 0) r.direction = 1'b1;
        else pct = -pct;
        pct = longint'(PWM_TOP) * pct / 100;
        r.compare = pct[CMP_W-1:0];
      end
      MODE_TEST: begin
        if (wave_tick == PHASE_Q1 || wave_tick == PHASE_Q3) wave_low = 1'b1;
        if (wave_tick == PHASE_HALF) wave_low = 1'b0;
        setpoint = wave_low ? -longint'(amplitude_ma) : longint'(amplitude_ma);
        run_pi(setpoint, longint'(meas), r.compare, r.direction);
        r.reference_ma = setpoint[15:0];
        next_tick = {1'b0, wave_tick} + 8'd1;
        if (next_tick >= TEST_LENGTH) begin
          next_tick  = '0;
          wave_low   = 1'b0;
          error_sum  = '0;
          r.finished = 1'b1;
        end
        wave_tick = next_tick[6:0];
      end
      MODE_TRACK: begin
        run_pi(longint'(target_ma), longint'(meas), r.compare, r.direction);
        r.reference_ma = target_ma;
      end
      default: begin
        // idle drives nothing and keeps all state
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pwm_result_t want;
    if (!rst_ni) begin
      kp_q16        = -24'sd13631;
      ki_q16        = -24'sd655;
      target_ma     = '0;
      integ_limit   = 16'd1000;
      amplitude_ma  = 15'd200;
      error_sum     = '0;
      wave_tick     = '0;
      wave_low      = 1'b0;
      fault_count   = 0;
      pending_results.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_KP:     kp_q16       = cfg_data_i;
          REG_KI:     ki_q16       = cfg_data_i;
          REG_TARGET: target_ma    = cfg_data_i[15:0];
          REG_LIMIT:  integ_limit  = cfg_data_i[15:0];
          REG_AMP:    amplitude_ma = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_results.push_back(predict_tick(mode_e'(s_tuser_i), s_tdata_i[15:0],
                                               s_tdata_i[23:16]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pending_results.size() == 0) begin
          if (fault_count < 10) begin
            $display("unexpected result: data %h last %b", m_tdata_i, m_tlast_i);
          end
          fault_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata_i[CMP_W-1:0] !== want.compare ||
              m_tdata_i[11] !== want.direction ||
              m_tlast_i !== want.finished ||
              m_tdata_i[27:12] !== want.reference_ma ||
              m_tdata_i[31:28] !== 4'b0000) begin
            if (fault_count < 10) begin
              $display("mismatch: expected cmp %0d dir %b fin %b ref %0d",
                       want.compare, want.direction, want.finished, want.reference_ma);
              $display("          actual   cmp %0d dir %b fin %b ref %0d pad %h",
                       m_tdata_i[CMP_W-1:0], m_tdata_i[11], m_tlast_i,
                       $signed(m_tdata_i[27:12]), m_tdata_i[31:28]);
            end
            fault_count++;
          end
        end
      end
      mismatches_o  <= fault_count;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// ===== tb/sv/motor_current_pi_controller_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the current controller: clock, reset, stimulus, watchdog and verdict.
module motor_current_pi_controller_unit_test;
  import mcpi_pkg::*;

  // Quiet cycles allowed before the run is declared hung; the longest legal
  // quiet stretch is set mostly by the receiver hold-off.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned PHASE_QUOTA = 155;
  localparam int unsigned NUM_PHASES  = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] measured_current, [23:16] manual_duty_percent
  logic [1:0]  s_axis_tuser;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [10:0] compare_value, [11] direction,
                               // [27:12] reference_current, [31:28] zero
  logic        m_axis_tlast;   // test_finished

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned ticks_sent;
  // set for stretches where neither side inserts idle cycles
  bit          no_gaps;

  motor_current_pi_controller_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  motor_current_pi_controller_unit_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tlast_i     (m_axis_tlast),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offer one tick on the input stream. Draw an idle gap first; with no gap
  // keep tvalid high straight into the next item so it is never toggled
  // twice within one step.
  task automatic offer_tick(mode_e op, logic [15:0] current, logic [7:0] duty);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {duty, current};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  // Drop tvalid and hold until every predicted result has been transferred.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Hold valid across back-to-back writes; the caller drops it after the last.
  task automatic write_reg(cfg_reg_e idx, logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Mostly currents close to the setpoints, so the loop does not just sit
  // at full drive, with some full-range and extreme values mixed in.
  function automatic logic [15:0] pick_current();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 16'(int'($urandom_range(0, 4000)) - 2000);
    if (roll < 8) return 16'($urandom);
    case ($urandom_range(0, 2))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'h0000;
    endcase
  endfunction

  // Load one full set of gains, target, limit and amplitude.
  task automatic program_regs(int unsigned setting);
    logic [23:0] kp, ki;
    logic [15:0] target, limit;
    logic [14:0] amp;
    case (setting)
      2: begin
        // top of every range
        kp = 24'h7FFFFF; ki = 24'h7FFFFF; target = 16'h7FFF;
        limit = 16'hFFFF; amp = 15'h7FFF;
      end
      3: begin
        // bottom of every range: integrator pinned at zero, flat test wave
        kp = 24'h800000; ki = 24'h800000; target = 16'h8000;
        limit = 16'h0000; amp = 15'h0000;
      end
      4: begin
        // no gain at all, full-range setpoints
        kp = '0; ki = '0; target = 16'($urandom);
        limit = 16'($urandom); amp = 15'($urandom);
      end
      6: begin
        // back to the power-up tuning
        kp = 24'(-13631); ki = 24'(-655); target = '0;
        limit = 16'd1000; amp = 15'd200;
      end
      default: begin
        // moderate gains so the output stays mostly out of saturation
        kp = 24'(int'($urandom_range(0, 80000)) - 40000);
        ki = 24'(int'($urandom_range(0, 8000)) - 4000);
        target = 16'(int'($urandom_range(0, 6000)) - 3000);
        limit = 16'($urandom_range(0, 5000));
        amp = 15'($urandom_range(0, 3000));
      end
    endcase
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_TARGET, {8'h00, target});
    write_reg(REG_LIMIT, {8'h00, limit});
    write_reg(REG_AMP, {9'h000, amp});
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic in bursts: whole square-wave runs and track stretches carry
  // the loop through all its states; pwm, idle and mixed noise break them up.
  task automatic random_traffic(int unsigned quota);
    int unsigned kind;
    logic [7:0]  duty;
    while (ticks_sent < quota) begin
      kind    = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 7) == 0);
      if (kind < 30) begin
        repeat (TEST_LENGTH) offer_tick(MODE_TEST, pick_current(), 8'($urandom));
      end else if (kind < 55) begin
        repeat ($urandom_range(8, 30)) offer_tick(MODE_TRACK, pick_current(), 8'($urandom));
      end else if (kind < 70) begin
        repeat ($urandom_range(5, 15)) begin
          duty = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(0, 200) - 100);
          offer_tick(MODE_PWM, 16'($urandom), duty);
        end
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 5)) offer_tick(MODE_IDLE, 16'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(5, 15)) begin
          offer_tick(mode_e'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_IDLE;
    ticks_sent    = 0;
    no_gaps       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks on the power-up settings.
    // Idle with every input bit at both extremes
    offer_tick(MODE_IDLE, 16'h7FFF, 8'h7F);
    offer_tick(MODE_IDLE, 16'h8000, 8'h80);
    // Manual pwm: full scale both ways, zero, smallest step, saturated duty
    offer_tick(MODE_PWM, 16'h0000, 8'd100);
    offer_tick(MODE_PWM, 16'h7FFF, 8'(-100));
    offer_tick(MODE_PWM, 16'h8000, 8'd0);
    offer_tick(MODE_PWM, 16'h0000, 8'd1);
    offer_tick(MODE_PWM, 16'h0000, 8'(-1));
    offer_tick(MODE_PWM, 16'h0000, 8'h7F);
    offer_tick(MODE_PWM, 16'h0000, 8'h80);
    offer_tick(MODE_PWM, 16'h0000, 8'd101);
    offer_tick(MODE_PWM, 16'h0000, 8'(-101));
    offer_tick(MODE_PWM, 16'h0000, 8'd50);
    // Track: extreme currents drive the integrator into both clamps
    offer_tick(MODE_TRACK, 16'h7FFF, 8'h00);
    offer_tick(MODE_TRACK, 16'h7FFF, 8'h00);
    offer_tick(MODE_TRACK, 16'h8000, 8'h00);
    offer_tick(MODE_TRACK, 16'h8000, 8'h00);
    offer_tick(MODE_TRACK, 16'd500, 8'h00);
    offer_tick(MODE_TRACK, 16'h0000, 8'h00);
    // Test ticks share the integrator left over from track
    offer_tick(MODE_TEST, 16'h0000, 8'h00);
    offer_tick(MODE_TEST, 16'h7FFF, 8'hFF);
    offer_tick(MODE_TEST, 16'h8000, 8'h00);
    random_traffic(PHASE_QUOTA / 2);

    // Each phase: go idle, retune, then random traffic.
    for (int unsigned phase = 1; phase <= NUM_PHASES; phase++) begin
      drain_results();
      program_regs(phase);
      random_traffic(phase * PHASE_QUOTA);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result receiver: random stalls per transfer, plus two long hold-offs
  // while the sender keeps offering, so the block fills up and blocks input.
  initial begin
    int unsigned taken;
    int unsigned gap;
    taken = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken == 300 || taken == 750) gap = LONG_HOLD;
      else gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mcpi_pkg.sv
rtl/motor_current_pi_controller_unit.sv
rtl/mcpi_checker.sv
tb/sv/motor_current_pi_controller_unit_checker.sv
tb/sv/motor_current_pi_controller_unit_test.sv
